// ===== hw/rtl/byte_block_device_ports_core_defines.svh =====
// Assertion macros shared by the checker of byte_block_device_ports_core.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef BYTE_BLOCK_DEVICE_PORTS_CORE_DEFINES_SVH
`define BYTE_BLOCK_DEVICE_PORTS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bbd_pkg.sv =====
// Shared types and constants of the byte block device.
// No dependencies; bbd_ctrl, bbd_datapath, the top level and the checker import it.
package bbd_pkg;

    // Store size and the index width it implies
    localparam int STORE_BYTES = 131072;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PTR_W       = 24;

    // Access kinds and port codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_ADDR = 1'b1;

    // Address assembly phases
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_HIGH = 2'd1;
    localparam logic [1:0] PHASE_MID  = 2'd2;

    // Status codes returned by a read of the address port
    localparam logic [7:0] STATUS_OK         = 8'd0;
    localparam logic [7:0] STATUS_OOB        = 8'd1;
    localparam logic [7:0] STATUS_INCOMPLETE = 8'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              take;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
    } bbd_cmd_t;

endpackage

// ===== hw/rtl/bbd_req_if.sv =====
// Request and response channel interfaces of the byte block device.
// No dependencies; the field widths are fixed here.
interface bbd_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic       port_select;
    logic [7:0] write_data;

    modport source (output valid, req_type, port_select, write_data, input ready);
    modport sink   (input valid, req_type, port_select, write_data, output ready);
endinterface

interface bbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       access_error;

    modport source (output valid, read_data, access_error, input ready);
    modport sink   (input valid, read_data, access_error, output ready);
endinterface

// ===== hw/rtl/bbd_ctrl.sv =====
// Controller of the byte block device: clearing pass, handshakes, result valid.
// Depends on bbd_pkg.
module bbd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output bbd_pkg::bbd_cmd_t cmd
);
    import bbd_pkg::*;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(STORE_BYTES - 1);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              res_valid_reg, res_valid_next;
    logic              take;

    // Accept a request once cleared and the result slot frees this cycle
    assign in_ready  = (state_reg == ST_RUN) && (!res_valid_reg || out_ready);
    assign take      = in_valid && in_ready;
    assign out_valid = res_valid_reg;

    assign cmd.take     = take;
    assign cmd.clr_we   = (state_reg == ST_CLEAR);
    assign cmd.clr_addr = clr_addr_reg;

    // Sweep the store once, then serve requests
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ENTRY)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb
    begin
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== hw/rtl/bbd_datapath.sv =====
// Datapath of the byte block device: pointer assembly, byte store, result registers.
// Depends on bbd_pkg.
module bbd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bbd_pkg::bbd_cmd_t cmd,
    input  logic              req_type,
    input  logic              port_select,
    input  logic [7:0]        write_data,
    output logic [7:0]        read_data,
    output logic              access_error
);
    import bbd_pkg::*;

    localparam logic [PTR_W:0] STORE_LIMIT = (PTR_W + 1)'(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        rd_q_reg;
    logic              res_mem_reg;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_err_reg;

    logic              is_addr, is_wr, in_bounds, refused;
    logic              data_rd_ok, data_wr_ok;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_idx, mem_waddr;
    logic [7:0]        mem_wdata;

    // Decode the request against the current pointer state
    assign is_addr    = (port_select == PORT_ADDR);
    assign is_wr      = (req_type == REQ_WRITE);
    assign in_bounds  = ({1'b0, ptr_reg} < STORE_LIMIT);
    assign refused    = (phase_reg != PHASE_IDLE) || !in_bounds;
    assign data_rd_ok = !is_addr && !is_wr && !refused;
    assign data_wr_ok = !is_addr && is_wr && !refused;
    assign mem_idx    = ptr_reg[ADDR_W-1:0];

    // Build the pointer one byte per address port write, high byte first
    always_comb
    begin
        ptr_next   = ptr_reg;
        phase_next = phase_reg;
        if (cmd.take && is_addr && is_wr)
        begin
            case (phase_reg)
                PHASE_IDLE:
                begin
                    ptr_next   = {write_data, 16'h0000};
                    phase_next = PHASE_HIGH;
                end
                PHASE_HIGH:
                begin
                    ptr_next   = {ptr_reg[23:16], write_data, 8'h00};
                    phase_next = PHASE_MID;
                end
                default:
                begin
                    ptr_next   = {ptr_reg[23:8], write_data};
                    phase_next = PHASE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            phase_reg <= PHASE_IDLE;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            phase_reg <= phase_next;
        end
    end

    // Pick status for address port reads, zero otherwise
    always_comb
    begin
        res_byte_next = 8'h00;
        if (is_addr && !is_wr)
        begin
            if (phase_reg != PHASE_IDLE)
            begin
                res_byte_next = STATUS_INCOMPLETE;
            end
            else if (!in_bounds)
            begin
                res_byte_next = STATUS_OOB;
            end
            else
            begin
                res_byte_next = STATUS_OK;
            end
        end
    end

    // Share the write port between the clearing pass and data writes
    assign mem_we    = cmd.clr_we || (cmd.take && data_wr_ok);
    assign mem_waddr = cmd.clr_we ? cmd.clr_addr : mem_idx;
    assign mem_wdata = cmd.clr_we ? 8'h00 : write_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Register the stored byte on an accepted data read
    always_ff @(posedge clk)
    begin
        if (cmd.take && data_rd_ok)
        begin
            rd_q_reg <= mem[mem_idx];
        end
    end

    // Capture the result of each accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            res_mem_reg  <= data_rd_ok;
            res_byte_reg <= res_byte_next;
            res_err_reg  <= !is_addr && refused;
        end
    end

    assign read_data    = res_mem_reg ? rd_q_reg : res_byte_reg;
    assign access_error = res_err_reg;

endmodule

// ===== hw/rtl/byte_block_device_ports_core.sv =====
// Top level of the byte block device: controller plus datapath.
// Depends on bbd_pkg, bbd_req_if, bbd_rsp_if, bbd_ctrl and bbd_datapath.
//
//  channel | role   | payload
//  --------+--------+-----------------------------------------
//  req     | sink   | req_type, port_select, write_data
//  rsp     | source | read_data, access_error
//
// One request per cycle after the clearing pass while responses are taken; its
// response shows in the cycle after acceptance, the single-port byte store
// being read at the edge that takes the request. After reset a clearing pass
// zeroes all STORE_BYTES (131072) bytes, one byte a cycle, with req.ready low.
// A stalled response holds; a new request is taken in the cycle the pending
// response leaves.
module byte_block_device_ports_core (
    input logic      clk,
    input logic      rst_n,
    bbd_req_if.sink  req,
    bbd_rsp_if.source rsp
);
    import bbd_pkg::*;

    bbd_cmd_t cmd;

    // Sequence clearing and handshakes
    bbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Hold pointer, store and result
    bbd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .port_select  (req.port_select),
        .write_data   (req.write_data),
        .read_data    (rsp.read_data),
        .access_error (rsp.access_error)
    );

endmodule

// ===== hw/rtl/bbd_checker.sv =====
// Port-level checker of the byte block device, bound to the top level.
// Depends on bbd_pkg and byte_block_device_ports_core_defines.svh.
`include "byte_block_device_ports_core_defines.svh"

module bbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       req_type,
    input logic       port_select,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic       access_error
);
    import bbd_pkg::*;

    logic take;

    assign take = in_valid && in_ready;

    // Every accepted request gives a response in the next cycle
    `BBD_ASSERT_NEXT(a_rsp_follows, take, out_valid)

    // Address port accesses never flag an error
    `BBD_ASSERT_NEXT(a_addr_no_err, take && (port_select == PORT_ADDR), !access_error)

    // Writes always return zero data
    `BBD_ASSERT_NEXT(a_write_zero, take && (req_type == REQ_WRITE), read_data == 8'h00)

    // A stalled response holds its payload
    `BBD_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready,
        out_valid && $stable(read_data) && $stable(access_error))

endmodule

bind byte_block_device_ports_core bbd_checker u_bbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .req_type     (req.req_type),
    .port_select  (req.port_select),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .read_data    (rsp.read_data),
    .access_error (rsp.access_error)
);

// ===== tb/bbd_access_checker.sv =====
// Scoreboard for byte_block_device_ports_core: predicts one response per request
// and compares it field by field. Depends on bbd_pkg and the bbd_req_if and
// bbd_rsp_if interfaces.
module bbd_access_checker
    import bbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bbd_req_if   req,
    bbd_rsp_if   rsp,
    output int   mismatch_count,
    output int   pending_count
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       access_error;
    } bbd_result_t;

    // Shadow copy of the device state
    logic [7:0]  shadow_store [int];
    logic [23:0] shadow_ptr;
    logic [1:0]  shadow_phase;

    bbd_result_t expected_results [$];
    int          error_total = 0;

    task automatic report_mismatch(input string msg);
        error_total++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Work out the response to one request and advance the shadow state
    function automatic bbd_result_t predict_access(input logic kind, input logic port,
                                                   input logic [7:0] byte_val);
        bbd_result_t res;
        logic        in_store;
        res      = '0;
        in_store = ({1'b0, shadow_ptr} < 25'(STORE_BYTES));
        if (port == PORT_ADDR) begin
            if (kind == REQ_WRITE) begin
                // Assemble the pointer, most significant byte first
                case (shadow_phase)
                    PHASE_IDLE:
                    begin
                        shadow_ptr   = {byte_val, 16'h0000};
                        shadow_phase = PHASE_HIGH;
                    end
                    PHASE_HIGH:
                    begin
                        shadow_ptr   = {shadow_ptr[23:16], byte_val, 8'h00};
                        shadow_phase = PHASE_MID;
                    end
                    default:
                    begin
                        shadow_ptr   = {shadow_ptr[23:8], byte_val};
                        shadow_phase = PHASE_IDLE;
                    end
                endcase
            end
            else if (shadow_phase != PHASE_IDLE)
                res.read_data = STATUS_INCOMPLETE;
            else if (!in_store)
                res.read_data = STATUS_OOB;
            else
                res.read_data = STATUS_OK;
        end
        else if (shadow_phase != PHASE_IDLE || !in_store) begin
            // Refuse data access: address incomplete or past the store
            res.access_error = 1'b1;
        end
        else if (kind == REQ_WRITE) begin
            shadow_store[int'(shadow_ptr)] = byte_val;
        end
        else if (shadow_store.exists(int'(shadow_ptr))) begin
            res.read_data = shadow_store[int'(shadow_ptr)];
        end
        return res;
    endfunction

    // Push predictions on accepted requests, pop and compare on responses
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        bbd_result_t want;
        if (!rst_n) begin
            shadow_store.delete();
            shadow_ptr   = '0;
            shadow_phase = PHASE_IDLE;
            expected_results.delete();
            pending_count <= 0;
        end
        else begin
            if (req.valid && req.ready)
                expected_results.push_back(predict_access(req.req_type, req.port_select,
                                                          req.write_data));
            if (rsp.valid && rsp.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("response with no request waiting");
                end
                else begin
                    want = expected_results.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data got %0h expected %0h",
                                                  rsp.read_data, want.read_data));
                    if (rsp.access_error !== want.access_error)
                        report_mismatch($sformatf("access_error got %0b expected %0b",
                                                  rsp.access_error, want.access_error));
                end
            end
            pending_count  <= expected_results.size();
            mismatch_count <= error_total;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the byte_block_device_ports_core testbench: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on bbd_pkg, the channel
// interfaces, the core and bbd_access_checker.
module tb;
    import bbd_pkg::*;

    localparam int QUIET_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_off_len = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int mismatch_count;
    int pending_count;

    bbd_req_if req_ch ();
    bbd_rsp_if rsp_ch ();

    byte_block_device_ports_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bbd_access_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request after a random idle gap; hold it until taken
    task automatic send_request(input logic kind, input logic port,
                                input logic [7:0] byte_val);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.port_select <= port;
        req_ch.write_data  <= byte_val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // Write the three pointer bytes to the address port
    task automatic set_pointer(input logic [23:0] ptr);
        send_request(REQ_WRITE, PORT_ADDR, ptr[23:16]);
        send_request(REQ_WRITE, PORT_ADDR, ptr[15:8]);
        send_request(REQ_WRITE, PORT_ADDR, ptr[7:0]);
    endtask

    // Mostly a few reusable in-store bytes, some at the store edge, some anywhere
    function automatic logic [23:0] pick_pointer();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return {7'd0, 1'($urandom_range(1)), ($urandom_range(1) ? 8'hFF : 8'h00),
                    4'h0, 4'($urandom_range(15))};
        else if (sel < 75)
            return 24'(32'h1FFF8 + $urandom_range(15));
        else
            return 24'($urandom);
    endfunction

    // Well-formed address/access groups with random content, plus broken ones
    task automatic run_random(input int n_items);
        int target;
        int op;
        int n_access;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(99) < 15) begin
                // Broken sequence: send one or two address bytes instead of three
                repeat ($urandom_range(1, 2))
                    send_request(REQ_WRITE, PORT_ADDR, 8'($urandom));
            end
            else begin
                set_pointer(pick_pointer());
            end
            n_access = $urandom_range(1, 6);
            repeat (n_access) begin
                op = $urandom_range(99);
                if (op < 40)
                    send_request(REQ_READ, PORT_DATA, 8'($urandom));
                else if (op < 80)
                    send_request(REQ_WRITE, PORT_DATA, 8'($urandom));
                else if (op < 92)
                    send_request(REQ_READ, PORT_ADDR, 8'($urandom));
                else
                    send_request(REQ_WRITE, PORT_ADDR, 8'($urandom));
            end
        end
    endtask

    // Response side: random stalls, or one long hold-off when asked
    initial
    begin : drive_response_ready
        int stall_left;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_len != 0) begin
                stall_left   = hold_off_len;
                hold_off_len = 0;
                rsp_ch.ready <= 1'b0;
                while (stall_left > 1) begin
                    @(posedge clk);
                    stall_left--;
                end
            end
            else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL byte_block_device_ports_core");
            $finish;
        end
    end

    initial
    begin : stimulus
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_READ;
        req_ch.port_select <= PORT_DATA;
        req_ch.write_data  <= 8'h00;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset state, incomplete address, store edges, far pointers
        send_request(REQ_READ, PORT_ADDR, 8'hFF);
        send_request(REQ_READ, PORT_DATA, 8'h00);
        send_request(REQ_WRITE, PORT_ADDR, 8'h01);
        send_request(REQ_READ, PORT_ADDR, 8'h00);
        send_request(REQ_READ, PORT_DATA, 8'h00);
        send_request(REQ_WRITE, PORT_DATA, 8'h3C);
        send_request(REQ_WRITE, PORT_ADDR, 8'hFF);
        send_request(REQ_READ, PORT_ADDR, 8'h00);
        send_request(REQ_WRITE, PORT_ADDR, 8'hFF);
        send_request(REQ_WRITE, PORT_DATA, 8'hA5);
        send_request(REQ_READ, PORT_DATA, 8'h00);
        send_request(REQ_READ, PORT_ADDR, 8'h00);
        set_pointer(24'h020000);
        send_request(REQ_READ, PORT_ADDR, 8'h00);
        send_request(REQ_WRITE, PORT_DATA, 8'hFF);
        send_request(REQ_READ, PORT_DATA, 8'hFF);
        set_pointer(24'hFFFFFF);
        send_request(REQ_READ, PORT_DATA, 8'h00);
        set_pointer(24'h000000);
        send_request(REQ_WRITE, PORT_DATA, 8'hFF);
        send_request(REQ_READ, PORT_DATA, 8'h00);

        // Random phases under different idle and stall mixes
        idle_pct = 0;  stall_pct = 0;  run_random(270);
        idle_pct = 58; stall_pct = 0;  run_random(270);
        idle_pct = 0;  stall_pct = 58; run_random(270);
        idle_pct = 11; stall_pct = 11; run_random(270);

        // Hold off responses while requests keep coming, so the input stalls
        idle_pct  = 0;
        stall_pct = 0;
        set_pointer(24'h000004);
        hold_off_len = 300;
        repeat (20) begin
            send_request(REQ_WRITE, PORT_DATA, 8'($urandom));
            send_request(REQ_READ, PORT_DATA, 8'($urandom));
        end

        // Drain outstanding responses
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS byte_block_device_ports_core");
        else
            $display("FAIL byte_block_device_ports_core");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_req_if.sv
hw/rtl/bbd_ctrl.sv
hw/rtl/bbd_datapath.sv
hw/rtl/byte_block_device_ports_core.sv
hw/rtl/bbd_checker.sv
tb/bbd_access_checker.sv
tb/tb.sv
